### rtl/olkr_pkg.sv
// Shared types and constants for the ordered list with key removal.
// No dependencies; imported by the interfaces, the top level and the checker.
package olkr_pkg;

	localparam int ID_W      = 16;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		REQ_APPEND     = 2'd0,
		REQ_POP_HEAD   = 2'd1,
		REQ_POP_TAIL   = 2'd2,
		REQ_REMOVE_KEY = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_SEARCH,
		ST_SHIFT,
		ST_FIN
	} state_t;

endpackage

### rtl/olkr_if.sv
// Request and result channel interfaces (valid/ready plus payload).
// Depends on olkr_pkg for the identifier width and the default depth.
interface olkr_req_if import olkr_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [1:0]      req_type;
	logic [ID_W-1:0] key_id;

	modport source (output valid, req_type, key_id, input ready);
	modport sink   (input valid, req_type, key_id, output ready);
endinterface

interface olkr_res_if import olkr_pkg::*; #(
	parameter int CW = $clog2(DEPTH_DEF + 1)
) ();
	logic            valid;
	logic            ready;
	logic [1:0]      status;
	logic [ID_W-1:0] removed_id;
	logic [CW-1:0]   entry_count;

	modport source (output valid, status, removed_id, entry_count, input ready);
	modport sink   (input valid, status, removed_id, entry_count, output ready);
endinterface

### rtl/olkr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module olkr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/ordered_list_with_key_removal_top.sv
// Ordered list of identifiers with removal at head, tail or by key.
// Depends on olkr_pkg, olkr_if (channels) and olkr_ram (entry store).
//
// Usage:
//   req channel: req_type and key_id; a transfer starts one request.
//   res channel: status, removed_id and entry_count, one result per request.
//   Requests are handled one at a time. Entries live in a circular store in
//   one RAM with registered reads; a sequencer reads, compares and writes back.
//   Steps from the request transfer to res.valid:
//     append, or any request that finds the list empty: execute, then finish
//     remove head / remove tail: execute (read issued), read wait, finish
//     remove by key: execute, search, then on a match shift, then finish;
//       without a match the search goes straight to finish (the search walks
//       from the head one entry per cycle, then the entries behind the match
//       move up one slot per cycle through the same read port).
//   The next request is taken in the idle cycle after the result is loaded.
//   The result sits in an output register; a new request is accepted while it
//   waits. If res.ready stays low, the following result holds in the sequencer
//   and no further request is taken.
//   Reset clears head and count, so the list is empty; store contents are
//   left as they are and never read before being written.
module ordered_list_with_key_removal_top import olkr_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	olkr_req_if.sink    req,
	olkr_res_if.source  res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t          state_q, state_d;
	req_t            req_type_q;
	logic [ID_W-1:0] key_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   pos_q;
	logic            valid_s1;
	logic [AW-1:0]   slot_s1, slot_s2;
	status_t         res_status_q;
	logic [ID_W-1:0] res_removed_q;
	logic            out_valid_q;
	status_t         out_status_q;
	logic [ID_W-1:0] out_removed_q;
	logic [CW-1:0]   out_count_q;

	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [ID_W-1:0] ram_wdata, ram_rdata;
	logic [CW-1:0]   rd_pos;
	logic            issue, match, found, not_found, shift_done;
	logic            is_full, is_empty, out_free;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
		input logic [CW-1:0] pos);
		logic [AW:0] sum;
		sum = {1'b0, head} + (AW+1)'(pos);
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	olkr_ram #(
		.WIDTH (ID_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign is_full    = (count_q == CW'(DEPTH));
	assign is_empty   = (count_q == '0);
	assign out_free   = !out_valid_q || res.ready;
	assign match      = valid_s1 && (ram_rdata == key_q);
	assign found      = (state_q == ST_SEARCH) && match;
	assign not_found  = (state_q == ST_SEARCH) && valid_s1 && !match && (pos_q == count_q);
	assign shift_done = (state_q == ST_SHIFT) && !valid_s1 && (pos_q == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (req_type_q == REQ_APPEND || is_empty) begin
					state_d = ST_FIN;
				end else if (req_type_q == REQ_REMOVE_KEY) begin
					state_d = ST_SEARCH;
				end else begin
					state_d = ST_RDWAIT;
				end
			end
			ST_RDWAIT: state_d = ST_FIN;
			ST_SEARCH: begin
				if (found) begin
					state_d = ST_SHIFT;
				end else if (not_found) begin
					state_d = ST_FIN;
				end
			end
			ST_SHIFT: begin
				if (shift_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM and handshake controls
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		issue     = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = slot_of(head_q, count_q);
		ram_wdata = key_q;
		rd_pos    = pos_q;
		unique case (state_q)
			ST_EXEC: begin
				if (req_type_q == REQ_APPEND) begin
					ram_we = !is_full;
				end else if (!is_empty && req_type_q != REQ_REMOVE_KEY) begin
					ram_re = 1'b1;
				end
				rd_pos = (req_type_q == REQ_POP_HEAD) ? '0 : count_q - 1'b1;
			end
			ST_SEARCH: begin
				issue  = (pos_q < count_q);
				ram_re = issue;
			end
			ST_SHIFT: begin
				issue     = (pos_q < count_q);
				ram_re    = issue;
				// the entry read last cycle moves into the slot read before it
				ram_we    = valid_s1;
				ram_waddr = slot_s2;
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
		ram_raddr = slot_of(head_q, rd_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (state_q == ST_EXEC && req_type_q == REQ_APPEND && !is_full) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == ST_RDWAIT) begin
				count_q <= count_q - 1'b1;
				if (req_type_q == REQ_POP_HEAD) begin
					head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
				end
			end
			if (shift_done) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			req_type_q <= req_t'(req.req_type);
			key_q      <= req.key_id;
		end
		if (issue) begin
			pos_q <= pos_q + 1'b1;
		end
		slot_s1 <= ram_raddr;
		slot_s2 <= slot_s1;
		unique case (state_q)
			ST_EXEC: begin
				pos_q         <= '0;
				res_removed_q <= '0;
				if (req_type_q == REQ_APPEND) begin
					res_status_q <= is_full ? STAT_FULL : STAT_OK;
				end else if (is_empty) begin
					res_status_q <= STAT_EMPTY;
				end else begin
					res_status_q <= STAT_OK;
				end
			end
			ST_RDWAIT: res_removed_q <= ram_rdata;
			ST_SEARCH: begin
				if (found) begin
					res_removed_q <= key_q;
				end else if (not_found) begin
					res_status_q <= STAT_NOT_FOUND;
				end
			end
			default: ;
		endcase
		if (state_q == ST_FIN && out_free) begin
			out_status_q  <= res_status_q;
			out_removed_q <= res_removed_q;
			out_count_q   <= count_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.status      = out_status_q;
	assign res.removed_id  = out_removed_q;
	assign res.entry_count = out_count_q;

endmodule

### rtl/olkr_checker.sv
// Port-level checks on the result channel of the top level, plus its bind.
// Depends on olkr_pkg and ordered_list_with_key_removal_top.
module olkr_checker import olkr_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [1:0]                  status,
	input logic [ID_W-1:0]             removed_id,
	input logic [$clog2(DEPTH+1)-1:0]  entry_count
);

	localparam int CW = $clog2(DEPTH + 1);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> entry_count <= CW'(DEPTH))
		else $error("entry_count above DEPTH");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == STAT_FULL |-> entry_count == CW'(DEPTH))
		else $error("full status with list not full");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == STAT_EMPTY |-> entry_count == '0)
		else $error("empty status with entries held");

	a_no_removal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != STAT_OK |-> removed_id == '0)
		else $error("removed_id set on failed request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(removed_id)
			&& $stable(entry_count))
		else $error("stalled result changed");

endmodule

bind ordered_list_with_key_removal_top olkr_checker #(.DEPTH(DEPTH)) u_olkr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.status      (res.status),
	.removed_id  (res.removed_id),
	.entry_count (res.entry_count)
);

### verif/ordered_list_with_key_removal_top_tb.sv
// Testbench for ordered_list_with_key_removal_top: directed and random request traffic,
// results checked in order against a queue-based model of the list.
// Depends on olkr_pkg, the olkr_req_if / olkr_res_if interfaces and the top level.
module ordered_list_with_key_removal_top_tb import olkr_pkg::*; ();

	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
	localparam int CYCLE_LIMIT = 300000;
	localparam int PRINT_CAP   = 40;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] removed_id;
		logic [CNT_W-1:0] entry_count;
	} list_result_t;

	logic clk;
	logic arst_n;

	olkr_req_if req_ch ();
	olkr_res_if res_ch ();

	ordered_list_with_key_removal_top #(.DEPTH(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	logic [ID_W-1:0] list_ids[$];       // model of the list, head at index 0
	list_result_t    pending_results[$];
	list_result_t    want;
	int              mismatch_count;
	int              cycle_count;
	int              tx_idle_pct;
	int              rx_idle_pct;

	always #4 clk = ~clk;

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.req_type = REQ_APPEND;
		req_ch.key_id  = '0;
		res_ch.ready   = 1'b0;
		mismatch_count = 0;
		tx_idle_pct    = 33;
		rx_idle_pct    = 72;
	end

	always @(negedge clk)
		res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	function automatic list_result_t predict_list_step(req_t kind, logic [ID_W-1:0] key);
		list_result_t r;
		int           idx;
		r.status     = STAT_OK;
		r.removed_id = '0;
		if (kind == REQ_APPEND) begin
			if (list_ids.size() >= LIST_DEPTH)
				r.status = STAT_FULL;
			else
				list_ids.push_back(key);
		end else if (list_ids.size() == 0) begin
			r.status = STAT_EMPTY;
		end else if (kind == REQ_POP_HEAD) begin
			r.removed_id = list_ids.pop_front();
		end else if (kind == REQ_POP_TAIL) begin
			r.removed_id = list_ids.pop_back();
		end else begin
			idx = -1;
			for (int i = 0; i < list_ids.size(); i++) begin
				if (list_ids[i] == key) begin
					idx = i;
					break;
				end
			end
			if (idx < 0) begin
				r.status = STAT_NOT_FOUND;
			end else begin
				r.removed_id = key;
				list_ids.delete(idx);
			end
		end
		r.entry_count = CNT_W'(list_ids.size());
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch %s: got %0h, expected %0h", what, got, exp_val);
		mismatch_count++;
	endtask

	// One request; valid stays high across back-to-back transfers.
	task automatic send_request(req_t kind, logic [ID_W-1:0] key);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.key_id   <= key;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_results.push_back(predict_list_step(kind, key));
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", res_ch.status, 0);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.status !== want.status)
					report_mismatch("status", res_ch.status, want.status);
				if (res_ch.removed_id !== want.removed_id)
					report_mismatch("removed_id", res_ch.removed_id, want.removed_id);
				if (res_ch.entry_count !== want.entry_count)
					report_mismatch("entry_count", res_ch.entry_count, want.entry_count);
			end
		end
	end

	task automatic test_empty_list();
		send_request(REQ_POP_HEAD, 16'h0000);
		send_request(REQ_POP_TAIL, 16'hFFFF);
		send_request(REQ_REMOVE_KEY, 16'h0000);
	endtask

	task automatic test_fill_and_overflow();
		send_request(REQ_APPEND, 16'h0000);
		send_request(REQ_APPEND, 16'hFFFF);
		send_request(REQ_APPEND, 16'h00A5);
		send_request(REQ_APPEND, 16'h00A5);
		for (int i = 0; i < LIST_DEPTH - 4; i++)
			send_request(REQ_APPEND, 16'h1000 + ID_W'(i));
		// list is full: this append is dropped
		send_request(REQ_APPEND, 16'hBEEF);
	endtask

	task automatic test_key_removal();
		send_request(REQ_REMOVE_KEY, 16'h0000);  // match at head
		send_request(REQ_REMOVE_KEY, 16'h00A5);  // duplicate, nearest head goes
		send_request(REQ_REMOVE_KEY, 16'h100B);  // match at tail
		send_request(REQ_REMOVE_KEY, 16'h7777);  // absent
	endtask

	task automatic test_list_ends();
		send_request(REQ_POP_TAIL, 16'h5A5A);
		send_request(REQ_POP_HEAD, 16'hA5A5);
	endtask

	function automatic logic [ID_W-1:0] pick_key(bit from_list);
		int sel;
		sel = $urandom_range(0, 99);
		if (from_list && list_ids.size() != 0 && sel < 60)
			return list_ids[$urandom_range(0, list_ids.size() - 1)];
		if (sel < 80)
			return ($urandom_range(0, 3) == 0) ? 16'hFFFF : ID_W'($urandom_range(0, 7));
		return ID_W'($urandom_range(0, 65535));
	endfunction

	task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
		bit   filling;
		int   sel;
		req_t kind;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		filling     = 1'b1;
		for (int n = 0; n < n_items; n++) begin
			// pick a fill or drain stretch at random every 40 requests so both full and empty are reached
			if (n % 40 == 0)
				filling = 1'($urandom_range(0, 1));
			sel = $urandom_range(0, 99);
			if (sel < 10)
				kind = req_t'($urandom_range(0, 3));
			else if (sel < (filling ? 68 : 33))
				kind = REQ_APPEND;
			else if (sel < (filling ? 77 : 55))
				kind = REQ_POP_HEAD;
			else if (sel < (filling ? 86 : 77))
				kind = REQ_POP_TAIL;
			else
				kind = REQ_REMOVE_KEY;
			send_request(kind, pick_key(kind == REQ_REMOVE_KEY));
		end
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_fill_and_overflow();
		test_key_removal();
		test_list_ends();
		test_random_traffic(175, 33, 72);
		test_random_traffic(175, 72, 33);
		test_random_traffic(175, 0, 0);

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * LIST_DEPTH) @(posedge clk);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
